>>> rtl/core/sorted_handle_index_map_macros.svh
// assertion macros shared by the sorted handle index map rtl
`ifndef SORTED_HANDLE_INDEX_MAP_MACROS_SVH
`define SORTED_HANDLE_INDEX_MAP_MACROS_SVH

// same-cycle implication, checked outside reset
`define SMAP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define SMAP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/smap_pkg.sv
// shared constants and types for the sorted handle index map
`timescale 1ns / 1ps

package smap_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int HANDLE_W    = 32;
  localparam int ORDER_W     = 10;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ENTRY_W     = HANDLE_W + ORDER_W;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [ORDER_W-1:0]  order;
  } entry_t;

  typedef struct packed {
    logic               valid;
    status_t            status;
    logic [ORDER_W-1:0] object_index;
  } resp_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;
  } mem_req_t;

endpackage

>>> rtl/core/smap_ram.sv
// generic simple dual-port ram, one write and one registered read port
`timescale 1ns / 1ps

module smap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_q[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/smap_ctrl.sv
// sequencer: binary search, shift-up insert, lookup and clear over the entry ram
`timescale 1ns / 1ps
`include "sorted_handle_index_map_macros.svh"

module smap_ctrl import smap_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req_valid,
  input  logic [1:0]          req_action,
  input  logic [HANDLE_W-1:0] req_handle,
  output logic                req_busy,
  input  logic                res_room,
  output resp_t               resp,
  output mem_req_t            mem,
  input  logic [ENTRY_W-1:0]  mem_rdata
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SRCH  = 8'b0000_0010,
    S_CMP   = 8'b0000_0100,
    S_CHECK = 8'b0000_1000,
    S_SHIFT = 8'b0001_0000,
    S_DRAIN = 8'b0010_0000,
    S_PUT   = 8'b0100_0000,
    S_RESP  = 8'b1000_0000
  } fsm_t;

  fsm_t                state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                wpend_r, wpend_nxt;
  logic [ADDR_W-1:0]   wpaddr_r, wpaddr_nxt;
  logic                ins_r, ins_nxt;
  logic [HANDLE_W-1:0] key_r, key_nxt;
  logic [CNT_W-1:0]    lo_r, lo_nxt;
  logic [CNT_W-1:0]    hi_r, hi_nxt;
  logic [ADDR_W-1:0]   mid_r, mid_nxt;
  logic [ADDR_W-1:0]   ptr_r, ptr_nxt;
  status_t             stat_r, stat_nxt;
  logic [ORDER_W-1:0]  idx_r, idx_nxt;

  logic [CNT_W:0]      mid_sum;
  logic [CNT_W-1:0]    mid_c;
  entry_t              rd_entry;
  logic                go_right;

  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_c    = mid_sum[CNT_W:1];
  assign rd_entry = entry_t'(mem_rdata);
  // insert looks for the first greater handle, lookup for the first not less
  assign go_right = ins_r ? (rd_entry.handle <= key_r) : (rd_entry.handle < key_r);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    wpend_nxt  = 1'b0;
    wpaddr_nxt = wpaddr_r;
    ins_nxt    = ins_r;
    key_nxt    = key_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    mid_nxt    = mid_r;
    ptr_nxt    = ptr_r;
    stat_nxt   = stat_r;
    idx_nxt    = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          key_nxt  = req_handle;
          ins_nxt  = (req_action == ACT_INSERT);
          lo_nxt   = '0;
          hi_nxt   = cnt_r;
          stat_nxt = STAT_NOT_FOUND;
          idx_nxt  = '0;
          unique case (action_t'(req_action))
            ACT_INSERT: begin
              if (cnt_r == CNT_W'(TABLE_DEPTH)) begin
                stat_nxt  = STAT_FULL;
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_SRCH;
              end
            end
            ACT_LOOKUP: begin
              if (req_handle == '0 || cnt_r == '0) begin
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_SRCH;
              end
            end
            ACT_CLEAR: begin
              cnt_nxt   = '0;
              stat_nxt  = STAT_OK;
              state_nxt = S_RESP;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_SRCH: begin
        if (lo_r < hi_r) begin
          mid_nxt   = mid_c[ADDR_W-1:0];
          state_nxt = S_CMP;
        end else if (ins_r) begin
          if (lo_r == cnt_r) begin
            state_nxt = S_PUT;
          end else begin
            ptr_nxt   = ADDR_W'(cnt_r - CNT_W'(1));
            state_nxt = S_SHIFT;
          end
        end else if (lo_r < cnt_r) begin
          state_nxt = S_CHECK;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_CMP: begin
        if (go_right) begin
          lo_nxt = CNT_W'(mid_r) + CNT_W'(1);
        end else begin
          hi_nxt = CNT_W'(mid_r);
        end
        state_nxt = S_SRCH;
      end
      S_CHECK: begin
        if (rd_entry.handle == key_r) begin
          stat_nxt = STAT_OK;
          idx_nxt  = rd_entry.order;
        end
        state_nxt = S_RESP;
      end
      S_SHIFT: begin
        wpend_nxt  = 1'b1;
        wpaddr_nxt = ptr_r + ADDR_W'(1);
        if (CNT_W'(ptr_r) == lo_r) begin
          state_nxt = S_DRAIN;
        end else begin
          ptr_nxt = ptr_r - ADDR_W'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_PUT;
      end
      S_PUT: begin
        cnt_nxt   = cnt_r + CNT_W'(1);
        stat_nxt  = STAT_OK;
        idx_nxt   = cnt_r[ORDER_W-1:0];
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (res_room) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // ram port steering
  always_comb begin
    unique case (state_r)
      S_SRCH:  mem.rd_addr = (lo_r < hi_r) ? mid_c[ADDR_W-1:0] : lo_r[ADDR_W-1:0];
      S_SHIFT: mem.rd_addr = ptr_r;
      default: mem.rd_addr = mid_r;
    endcase
    mem.wr_en   = wpend_r || (state_r == S_PUT);
    mem.wr_addr = (state_r == S_PUT) ? lo_r[ADDR_W-1:0] : wpaddr_r;
    mem.wr_data = (state_r == S_PUT) ? {key_r, cnt_r[ORDER_W-1:0]} : mem_rdata;
  end

  assign req_busy          = (state_r != S_IDLE);
  assign resp.valid        = (state_r == S_RESP);
  assign resp.status       = stat_r;
  assign resp.object_index = idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      wpend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      wpend_r <= wpend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wpaddr_r <= wpaddr_nxt;
    ins_r    <= ins_nxt;
    key_r    <= key_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
    ptr_r    <= ptr_nxt;
    stat_r   <= stat_nxt;
    idx_r    <= idx_nxt;
  end

  `SMAP_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(TABLE_DEPTH), "entry count past depth")
  `SMAP_ASSERT_NOW(a_mid_range, state_r == S_CMP, CNT_W'(mid_r) >= lo_r && CNT_W'(mid_r) < hi_r, "probe outside search window")
  `SMAP_ASSERT_NOW(a_shift_gap, state_r == S_SHIFT && wpend_r, {1'b0, wpaddr_r} == {1'b0, ptr_r} + (ADDR_W + 1)'(2), "shift write overlaps read")
  `SMAP_ASSERT_NEXT(a_take_busy, req_valid && !req_busy, req_busy, "request taken but sequencer idle")

endmodule

>>> rtl/core/sorted_handle_index_map.sv
// top level of the sorted handle index map: entry ram, sequencer, result register
// The block keeps up to 1024 32-bit handles in ascending order in one 1024 x 42
// simple dual-port ram (handle plus 10-bit order number), and takes one request
// at a time: insert, lookup or clear. Every request gives exactly one result.
// Each binary-search step passes through a read state and a compare state; an
// insert then opens its slot by shifting the entries above it up, the shift
// moving one entry a cycle through the ram. Clear, a lookup of handle zero or
// of an empty table, and an insert into a full table skip the search. After
// each result the sequencer returns to idle before the next request is taken.
// The result sits in an output register, so a new request is taken while an
// earlier result still waits for the consumer. No clearing pass is needed after
// reset: only entries below the fill count are ever read.
`timescale 1ns / 1ps
`include "sorted_handle_index_map_macros.svh"

module sorted_handle_index_map import smap_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // request channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_action,
  input  logic [HANDLE_W-1:0] in_handle,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic [ORDER_W-1:0]  out_object_index
);

  resp_t              resp;
  mem_req_t           mem;
  logic [ENTRY_W-1:0] mem_rdata;
  logic               busy;
  logic               res_room;

  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r;
  logic [ORDER_W-1:0] out_index_r;

  // sorted handle and order number table
  smap_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem.wr_en),
    .wr_addr (mem.wr_addr),
    .wr_data (mem.wr_data),
    .rd_addr (mem.rd_addr),
    .rd_data (mem_rdata)
  );

  // search, shift and bookkeeping
  smap_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_valid),
    .req_action (in_action),
    .req_handle (in_handle),
    .req_busy   (busy),
    .res_room   (res_room),
    .resp       (resp),
    .mem        (mem),
    .mem_rdata  (mem_rdata)
  );

  // one request in flight at a time
  assign in_stall = busy;

  // output register frees up when empty or being drained this cycle
  assign res_room      = !out_valid_r || !out_stall;
  assign out_valid_nxt = (resp.valid && res_room) || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (resp.valid && res_room) begin
      out_status_r <= resp.status;
      out_index_r  <= resp.object_index;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_object_index = out_index_r;

  `SMAP_ASSERT_NEXT(a_res_loaded, resp.valid && res_room, out_valid_r, "result not latched")
  `SMAP_ASSERT_NOW(a_res_waits, resp.valid && !res_room, out_valid_r && out_stall, "result blocked without cause")

endmodule

>>> verif/smap_checker.sv
// request/result checker for the sorted handle index map: predicts every result and compares
`timescale 1ns / 1ps

module smap_checker import smap_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [1:0]          in_action,
  input  logic [HANDLE_W-1:0] in_handle,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [1:0]          out_status,
  input  logic [ORDER_W-1:0]  out_object_index,
  output int unsigned         fail_count,
  output int unsigned         pending
);

  typedef struct packed {
    status_t            status;
    logic [ORDER_W-1:0] order;
  } answer_t;

  // shadow copy of the sorted table
  logic [HANDLE_W-1:0] key_table   [TABLE_DEPTH];
  logic [ORDER_W-1:0]  order_table [TABLE_DEPTH];
  int unsigned         fill;
  answer_t             answer_q[$];
  answer_t             oldest;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    fail_count++;
    $display("%0t smap check: %s got %0d want %0d", $time, what, got, want);
  endtask

  // binary search: first slot above key (after_equal) or first slot not below key
  function automatic int unsigned find_slot(input logic [HANDLE_W-1:0] key, input bit after_equal);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = fill;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (key_table[mid] < key || (after_equal && key_table[mid] == key)) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic answer_t apply_request(input logic [1:0] act, input logic [HANDLE_W-1:0] key);
    answer_t     ans;
    int unsigned pos;
    ans.status = STAT_NOT_FOUND;
    ans.order  = '0;
    case (act)
      ACT_INSERT: begin
        if (fill >= TABLE_DEPTH) begin
          ans.status = STAT_FULL;
        end else begin
          pos = find_slot(key, 1'b1);
          for (int unsigned i = fill; i > pos; i--) begin
            key_table[i]   = key_table[i-1];
            order_table[i] = order_table[i-1];
          end
          key_table[pos]   = key;
          order_table[pos] = ORDER_W'(fill);
          ans.order        = ORDER_W'(fill);
          ans.status       = STAT_OK;
          fill++;
        end
      end
      ACT_LOOKUP: begin
        if (key != '0 && fill > 0) begin
          pos = find_slot(key, 1'b0);
          if (pos < fill && key_table[pos] == key) begin
            ans.status = STAT_OK;
            ans.order  = order_table[pos];
          end
        end
      end
      ACT_CLEAR: begin
        fill       = 0;
        ans.status = STAT_OK;
      end
      default: ;
    endcase
    return ans;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      fill       = 0;
      fail_count = 0;
      answer_q.delete();
    end else begin
      if (in_valid && !in_stall) answer_q.push_back(apply_request(in_action, in_handle));
      if (out_valid && !out_stall) begin
        if (answer_q.size() == 0) begin
          report("result with nothing outstanding, status", out_status, 0);
        end else begin
          oldest = answer_q.pop_front();
          if (out_status !== oldest.status) report("status", out_status, oldest.status);
          if (out_object_index !== oldest.order)
            report("object index", out_object_index, oldest.order);
        end
      end
    end
    pending = answer_q.size();
  end

endmodule

>>> verif/tb_sorted_handle_index_map.sv
// testbench top for the sorted handle index map: stimulus, idling, watchdog and verdict
`timescale 1ns / 1ps

module tb_sorted_handle_index_map;
  import smap_pkg::*;

  // reserved action code, answered as not found
  localparam logic [1:0]  ACT_RESERVED = 2'd3;
  localparam int unsigned FILL_REQS    = 300;
  localparam int unsigned RANDOM_REQS  = 250;
  // quiet cycles allowed; worst correct case is a shift of the whole table
  localparam int unsigned STALL_LIMIT  = 20000;

  logic                clk;
  logic                rst_n            = 1'b0;
  logic                in_valid         = 1'b0;
  logic                in_stall;
  logic [1:0]          in_action        = ACT_INSERT;
  logic [HANDLE_W-1:0] in_handle        = '0;
  logic                out_valid;
  logic                out_stall        = 1'b0;
  logic [1:0]          out_status;
  logic [ORDER_W-1:0]  out_object_index;

  int unsigned fail_count;
  int unsigned pending;

  // stimulus bookkeeping: handles believed to be in the table
  logic [HANDLE_W-1:0] live_keys[$];
  int unsigned         table_size;
  int unsigned         peak_size;
  int unsigned         n_insert, n_refused, n_lookup, n_clear, n_reserved;
  int unsigned         idle_cycles;
  bit                  no_idle;

  sorted_handle_index_map uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_handle        (in_handle),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_object_index (out_object_index)
  );

  smap_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_handle        (in_handle),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_object_index (out_object_index),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: ends the run if neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending);
        $display("sorted_handle_index_map: mismatch");
        $finish;
      end
    end
  end

  // result side: a random hold-off before each result, none in calm stretches
  initial begin
    int unsigned hold;
    @(posedge clk iff rst_n);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 5);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      // stall and valid are settled by the falling edge
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
    end
  end

  // one request: optional gap, then hold it until taken; valid stays high afterwards
  task automatic send_request(input logic [1:0] act, input logic [HANDLE_W-1:0] key);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_handle <= key;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    // track what the table should now hold, for shaping later requests
    case (act)
      ACT_INSERT: begin
        n_insert++;
        if (table_size >= TABLE_DEPTH) begin
          n_refused++;
        end else begin
          live_keys.push_back(key);
          table_size++;
          if (table_size > peak_size) peak_size = table_size;
        end
      end
      ACT_LOOKUP: n_lookup++;
      ACT_CLEAR: begin
        n_clear++;
        live_keys.delete();
        table_size = 0;
      end
      default: n_reserved++;
    endcase
  endtask

  function automatic logic [HANDLE_W-1:0] pick_live();
    if (live_keys.size() == 0) return HANDLE_W'($urandom);
    return live_keys[$urandom_range(0, live_keys.size() - 1)];
  endfunction

  initial begin
    logic [HANDLE_W-1:0] key, fill_first, fill_last;
    int unsigned         pick, cap;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners: empty table, zero handle, extremes, duplicates, reserved code
    send_request(ACT_LOOKUP,   32'h0000_0005);
    send_request(ACT_INSERT,   32'h0000_0000);
    send_request(ACT_LOOKUP,   32'h0000_0000);
    send_request(ACT_INSERT,   32'hFFFF_FFFF);
    send_request(ACT_INSERT,   32'h0000_0001);
    send_request(ACT_INSERT,   32'h0000_0001);
    send_request(ACT_INSERT,   32'h8000_0000);
    send_request(ACT_LOOKUP,   32'h0000_0001);
    send_request(ACT_LOOKUP,   32'hFFFF_FFFF);
    send_request(ACT_LOOKUP,   32'h7FFF_FFFF);
    send_request(ACT_LOOKUP,   32'h0000_0002);
    send_request(ACT_RESERVED, 32'hFFFF_FFFF);
    send_request(ACT_INSERT,   32'hFFFF_FFFF);
    send_request(ACT_LOOKUP,   32'hFFFF_FFFF);
    send_request(ACT_INSERT,   32'h0000_0000);
    send_request(ACT_LOOKUP,   32'h8000_0000);
    send_request(ACT_CLEAR,    32'hFFFF_FFFF);
    send_request(ACT_LOOKUP,   32'h0000_0001);
    send_request(ACT_INSERT,   32'h0000_0005);
    send_request(ACT_LOOKUP,   32'h0000_0005);
    send_request(ACT_CLEAR,    32'h0000_0000);

    // fill phase: ascending appends are cheap, then one smallest handle shifts everything
    fill_first = '0;
    fill_last  = '0;
    for (int unsigned i = 1; i < FILL_REQS; i++) begin
      if (i % 64 == 0) no_idle = ($urandom_range(0, 2) == 0);
      key = HANDLE_W'(i * 32'd4_000_000 + $urandom_range(0, 999));
      if (i == 1) fill_first = key;
      fill_last = key;
      send_request(ACT_INSERT, key);
    end
    no_idle = 1'b0;
    send_request(ACT_INSERT, 32'h0000_0001);
    // every entry has moved up by one slot
    send_request(ACT_LOOKUP, 32'h0000_0001);
    send_request(ACT_LOOKUP, fill_first);
    send_request(ACT_LOOKUP, fill_last);
    send_request(ACT_LOOKUP, fill_last + 1);
    send_request(ACT_LOOKUP, 32'h0000_0000);
    send_request(ACT_CLEAR,  32'h1234_5678);

    // random part: small tables cleared now and then, lookups mostly of live handles
    cap = $urandom_range(8, 96);
    for (int unsigned k = 0; k < RANDOM_REQS; k++) begin
      if (k % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (table_size >= cap) begin
        send_request(ACT_CLEAR, HANDLE_W'($urandom));
        cap = $urandom_range(8, 96);
      end else if (pick < 45) begin
        pick = $urandom_range(0, 9);
        if (pick < 3)      key = HANDLE_W'($urandom_range(0, 15));
        else if (pick < 5) key = pick_live();
        else               key = HANDLE_W'($urandom);
        send_request(ACT_INSERT, key);
      end else if (pick < 92) begin
        pick = $urandom_range(0, 9);
        if (pick < 6)      key = pick_live();
        else if (pick < 7) key = '0;
        else if (pick < 8) key = pick_live() + HANDLE_W'($urandom_range(0, 1) ? 1 : -1);
        else               key = HANDLE_W'($urandom);
        send_request(ACT_LOOKUP, key);
      end else if (pick < 96) begin
        send_request(ACT_CLEAR, HANDLE_W'($urandom));
      end else begin
        send_request(ACT_RESERVED, HANDLE_W'($urandom));
      end
    end

    in_valid <= 1'b0;
    // let the checker log the last request, drain, then a short quiet spell
    @(negedge clk);
    wait (pending == 0);
    repeat (64) @(posedge clk);

    $display("covered %0d inserts (%0d refused on a full table), %0d lookups, %0d clears,",
             n_insert, n_refused, n_lookup, n_clear);
    $display("%0d reserved-code requests; table peaked at %0d entries",
             n_reserved, peak_size);
    if (fail_count == 0 && pending == 0) begin
      $display("sorted_handle_index_map: match");
    end else begin
      $display("sorted_handle_index_map: mismatch");
    end
    $finish;
  end

endmodule
